// ----- rtl/gfba_pkg.sv -----
// ============================================================================
// gfba_pkg
// Shared widths, codes and control structures of the grouped free block
// allocator.
// ============================================================================
package gfba_pkg;

   // Field widths of the transactions.
   localparam int OP_W     = 2;
   localparam int WORD_W   = 24;
   localparam int STATUS_W = 3;

   // Default number of entries in one group.
   localparam int GROUP_SIZE_DEF = 63;

   // Operation codes of a request.
   localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
   localparam logic [OP_W-1:0] OP_REFILL = 2'd2;
   localparam logic [OP_W-1:0] OP_SYNC   = 2'd3;

   // Status codes of a response.
   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOSPACE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REFILL  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_SPILL   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SEQERR  = 3'd4;

   // Datapath actions issued by the controller.
   typedef logic [3:0] action_type;
   localparam action_type ACT_NONE          = 4'd0;
   localparam action_type ACT_SYNC          = 4'd1;
   localparam action_type ACT_SEQERR        = 4'd2;
   localparam action_type ACT_REFILL        = 4'd3;
   localparam action_type ACT_NOSPACE       = 4'd4;
   localparam action_type ACT_NOSPACE_CLEAR = 4'd5;
   localparam action_type ACT_ALLOC         = 4'd6;
   localparam action_type ACT_MARK          = 4'd7;
   localparam action_type ACT_FREE          = 4'd8;
   localparam action_type ACT_SPILL_HEAD    = 4'd9;
   localparam action_type ACT_SPILL_WORD    = 4'd10;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       latch;
      logic       rd_spill;
      action_type action;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            refill_pending;
      logic            count_zero;
      logic            count_full;
      logic            top_zero;
      logic            spill_last;
      logic            out_free;
   } stat_type;

endpackage

// ----- rtl/gfba_req_if.sv -----
// ============================================================================
// gfba_req_if
// Request channel of the allocator: valid/ready handshake with the
// operation, the freed block number and a refill word.
// ============================================================================
interface gfba_req_if;

   logic                          valid;
   logic                          ready;
   logic [gfba_pkg::OP_W-1:0]     operation;
   logic [gfba_pkg::WORD_W-1:0]   block_number;
   logic [gfba_pkg::WORD_W-1:0]   fill_word;

   modport source (output valid, output operation, output block_number,
                   output fill_word, input ready);
   modport sink   (input valid, input operation, input block_number,
                   input fill_word, output ready);

endinterface

// ----- rtl/gfba_rsp_if.sv -----
// ============================================================================
// gfba_rsp_if
// Response channel of the allocator: valid/ready handshake with the status,
// block number, spill word, last marker and modified flag.
// ============================================================================
interface gfba_rsp_if;

   logic                            valid;
   logic                            ready;
   logic [gfba_pkg::STATUS_W-1:0]   status;
   logic [gfba_pkg::WORD_W-1:0]     block_number_out;
   logic [gfba_pkg::WORD_W-1:0]     spill_word;
   logic                            last;
   logic                            modified;

   modport source (output valid, output status, output block_number_out,
                   output spill_word, output last, output modified,
                   input ready);
   modport sink   (input valid, input status, input block_number_out,
                   input spill_word, input last, input modified,
                   output ready);

endinterface

// ----- rtl/grouped_free_block_allocator_unit.sv -----
// ============================================================================
// grouped_free_block_allocator_unit
// Grouped free block list: a stack of free block numbers with refill from
// and spill into chained group blocks, plus a modified flag.
// ============================================================================
//
//   Channel    Direction  Handshake     Payload
//   req_chan   in         valid/ready   operation, block_number, fill_word
//   rsp_chan   out        valid/ready   status, block_number_out, spill_word,
//                                       last, modified
//
// One request is taken at a time. Allocate, sync, refill words and most
// frees are accepted, then executed against the registered stack read; a
// free into an empty stack first plants the end marker. A free into a full
// stack streams GROUP_SIZE+1 spill transactions, each word read through the
// single memory read port. Reset is synchronous and clears the count, refill
// counter, modified flag and output valid; the stack memory is not cleared.
// A stalled response holds the controller in place, and the next request is
// taken while the last response still waits in the output register.
//
module grouped_free_block_allocator_unit #(
   parameter int GROUP_SIZE = gfba_pkg::GROUP_SIZE_DEF
) (
   input  logic         clock,
   input  logic         reset,
   gfba_req_if.sink     req_chan,
   gfba_rsp_if.source   rsp_chan
);

   gfba_pkg::cmd_type  cmd;
   gfba_pkg::stat_type stat;

   // Controller.
   gfba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath.
   gfba_dp #(
      .GROUP_SIZE (GROUP_SIZE)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_operation        (req_chan.operation),
      .req_block_number     (req_chan.block_number),
      .req_fill_word        (req_chan.fill_word),
      .rsp_valid            (rsp_chan.valid),
      .rsp_ready            (rsp_chan.ready),
      .rsp_status           (rsp_chan.status),
      .rsp_block_number_out (rsp_chan.block_number_out),
      .rsp_spill_word       (rsp_chan.spill_word),
      .rsp_last             (rsp_chan.last),
      .rsp_modified         (rsp_chan.modified)
   );

endmodule

// ----- rtl/gfba_ctrl.sv -----
// ============================================================================
// gfba_ctrl
// Controller of the allocator: accepts one request at a time, picks the
// datapath action and walks through a spill run word by word.
// ============================================================================
module gfba_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  gfba_pkg::stat_type  stat,
   output gfba_pkg::cmd_type   cmd
);

   localparam logic [1:0] S_IDLE     = 2'd0;
   localparam logic [1:0] S_EXEC     = 2'd1;
   localparam logic [1:0] S_SPILL_RD = 2'd2;
   localparam logic [1:0] S_SPILL_WR = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Next state and command decode.
   always_comb begin
      state_in     = state_ff;
      req_ready    = (state_ff == S_IDLE);
      cmd.latch    = req_valid && (state_ff == S_IDLE);
      cmd.rd_spill = (state_ff == S_SPILL_RD) || (state_ff == S_SPILL_WR);
      cmd.action   = gfba_pkg::ACT_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // A free into an empty stack first plants the end marker.
            if (stat.op == gfba_pkg::OP_FREE && !stat.refill_pending &&
                stat.count_zero) begin
               cmd.action = gfba_pkg::ACT_MARK;
            end else if (stat.out_free) begin
               state_in = S_IDLE;
               if (stat.op == gfba_pkg::OP_SYNC) begin
                  cmd.action = gfba_pkg::ACT_SYNC;
               end else if (stat.op == gfba_pkg::OP_REFILL) begin
                  cmd.action = stat.refill_pending ? gfba_pkg::ACT_REFILL
                                                   : gfba_pkg::ACT_SEQERR;
               end else if (stat.refill_pending) begin
                  cmd.action = gfba_pkg::ACT_SEQERR;
               end else if (stat.op == gfba_pkg::OP_ALLOC) begin
                  if (stat.count_zero) begin
                     cmd.action = gfba_pkg::ACT_NOSPACE;
                  end else if (stat.top_zero) begin
                     cmd.action = gfba_pkg::ACT_NOSPACE_CLEAR;
                  end else begin
                     cmd.action = gfba_pkg::ACT_ALLOC;
                  end
               end else if (stat.count_full) begin
                  cmd.action = gfba_pkg::ACT_SPILL_HEAD;
                  state_in   = S_SPILL_RD;
               end else begin
                  cmd.action = gfba_pkg::ACT_FREE;
               end
            end
         end
         S_SPILL_RD: begin
            state_in = S_SPILL_WR;
         end
         S_SPILL_WR: begin
            if (stat.out_free) begin
               cmd.action = gfba_pkg::ACT_SPILL_WORD;
               state_in   = stat.spill_last ? S_IDLE : S_SPILL_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/gfba_dp.sv -----
// ============================================================================
// gfba_dp
// Datapath of the allocator: free block stack memory, count and refill
// registers, modified flag and the response output register.
// ============================================================================
module gfba_dp #(
   parameter int GROUP_SIZE = gfba_pkg::GROUP_SIZE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  gfba_pkg::cmd_type               cmd,
   output gfba_pkg::stat_type              stat,
   input  logic [gfba_pkg::OP_W-1:0]       req_operation,
   input  logic [gfba_pkg::WORD_W-1:0]     req_block_number,
   input  logic [gfba_pkg::WORD_W-1:0]     req_fill_word,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [gfba_pkg::STATUS_W-1:0]   rsp_status,
   output logic [gfba_pkg::WORD_W-1:0]     rsp_block_number_out,
   output logic [gfba_pkg::WORD_W-1:0]     rsp_spill_word,
   output logic                            rsp_last,
   output logic                            rsp_modified
);

   localparam int CW = $clog2(GROUP_SIZE + 1);
   localparam int AW = $clog2(GROUP_SIZE);
   localparam int RW = $clog2(GROUP_SIZE + 2);
   localparam int WW = gfba_pkg::WORD_W;

   // Latched request.
   logic [gfba_pkg::OP_W-1:0] op_ff;
   logic [WW-1:0]             blk_ff;
   logic [WW-1:0]             word_ff;

   // Allocator state.
   logic [CW-1:0] count_ff, count_in;
   logic [RW-1:0] remain_ff, remain_in;
   logic          mod_ff, mod_in;
   logic [AW-1:0] spill_idx_ff, spill_idx_in;

   // Stack memory and its ports.
   logic [WW-1:0] mem [GROUP_SIZE];
   logic [WW-1:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [WW-1:0] wr_data;

   // Response output register.
   logic                          out_valid_ff, out_valid_in;
   logic                          load;
   logic [gfba_pkg::STATUS_W-1:0] st_ff, st_in;
   logic [WW-1:0]                 bo_ff, bo_in;
   logic [WW-1:0]                 sw_ff, sw_in;
   logic                          last_ff, last_in;
   logic                          omod_ff;

   logic [CW-1:0] count_dec;
   logic [RW-1:0] fill_idx;
   logic          out_free;
   logic          spill_last;

   assign count_dec  = count_ff - CW'(1);
   assign fill_idx   = RW'(GROUP_SIZE) - remain_ff;
   assign out_free   = !out_valid_ff || rsp_ready;
   assign spill_last = (spill_idx_ff == AW'(GROUP_SIZE - 1));

   // The top entry is read continuously; a spill run reads by its index.
   assign rd_addr = cmd.rd_spill ? spill_idx_ff : count_dec[AW-1:0];

   // Status toward the controller.
   always_comb begin
      stat.op             = op_ff;
      stat.refill_pending = (remain_ff != '0);
      stat.count_zero     = (count_ff == '0);
      stat.count_full     = (count_ff >= CW'(GROUP_SIZE));
      stat.top_zero       = (rd_data_ff == '0);
      stat.spill_last     = spill_last;
      stat.out_free       = out_free;
   end

   // Action execution.
   always_comb begin
      count_in     = count_ff;
      remain_in    = remain_ff;
      mod_in       = mod_ff;
      spill_idx_in = spill_idx_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      load         = 1'b0;
      st_in        = gfba_pkg::ST_OK;
      bo_in        = '0;
      sw_in        = '0;
      last_in      = 1'b1;
      case (cmd.action)
         gfba_pkg::ACT_SYNC: begin
            mod_in = 1'b0;
            load   = 1'b1;
         end
         gfba_pkg::ACT_SEQERR: begin
            load  = 1'b1;
            st_in = gfba_pkg::ST_SEQERR;
         end
         gfba_pkg::ACT_REFILL: begin
            // The first word is the count, the rest fill the group in order.
            load      = 1'b1;
            remain_in = remain_ff - RW'(1);
            if (remain_ff == RW'(GROUP_SIZE + 1)) begin
               count_in = (word_ff > WW'(GROUP_SIZE)) ? CW'(GROUP_SIZE)
                                                       : word_ff[CW-1:0];
            end else begin
               wr_en   = 1'b1;
               wr_addr = fill_idx[AW-1:0];
               wr_data = word_ff;
            end
         end
         gfba_pkg::ACT_NOSPACE: begin
            load  = 1'b1;
            st_in = gfba_pkg::ST_NOSPACE;
         end
         gfba_pkg::ACT_NOSPACE_CLEAR: begin
            count_in = '0;
            load     = 1'b1;
            st_in    = gfba_pkg::ST_NOSPACE;
         end
         gfba_pkg::ACT_ALLOC: begin
            count_in = count_dec;
            mod_in   = 1'b1;
            load     = 1'b1;
            bo_in    = rd_data_ff;
            if (count_ff == CW'(1)) begin
               st_in     = gfba_pkg::ST_REFILL;
               remain_in = RW'(GROUP_SIZE + 1);
            end
         end
         gfba_pkg::ACT_MARK: begin
            wr_en    = 1'b1;
            count_in = CW'(1);
            mod_in   = 1'b1;
         end
         gfba_pkg::ACT_FREE: begin
            wr_en    = 1'b1;
            wr_addr  = count_ff[AW-1:0];
            wr_data  = blk_ff;
            count_in = count_ff + CW'(1);
            mod_in   = 1'b1;
            load     = 1'b1;
         end
         gfba_pkg::ACT_SPILL_HEAD: begin
            mod_in       = 1'b1;
            load         = 1'b1;
            st_in        = gfba_pkg::ST_SPILL;
            bo_in        = blk_ff;
            sw_in        = WW'(count_ff);
            last_in      = 1'b0;
            spill_idx_in = '0;
         end
         gfba_pkg::ACT_SPILL_WORD: begin
            load         = 1'b1;
            st_in        = gfba_pkg::ST_SPILL;
            bo_in        = blk_ff;
            sw_in        = rd_data_ff;
            last_in      = spill_last;
            spill_idx_in = spill_idx_ff + AW'(1);
            // After the last word the stack restarts with the freed block.
            if (spill_last) begin
               wr_en        = 1'b1;
               wr_data      = blk_ff;
               count_in     = CW'(1);
               spill_idx_in = '0;
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   // Output valid tracking.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         remain_ff    <= '0;
         mod_ff       <= 1'b0;
         spill_idx_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         mod_ff       <= mod_in;
         spill_idx_ff <= spill_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Request latch and response payload.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff   <= req_operation;
         blk_ff  <= req_block_number;
         word_ff <= req_fill_word;
      end
      if (load) begin
         st_ff   <= st_in;
         bo_ff   <= bo_in;
         sw_ff   <= sw_in;
         last_ff <= last_in;
         omod_ff <= mod_in;
      end
   end

   // Stack memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_status           = st_ff;
   assign rsp_block_number_out = bo_ff;
   assign rsp_spill_word       = sw_ff;
   assign rsp_last             = last_ff;
   assign rsp_modified         = omod_ff;

endmodule

// ----- dv/grouped_free_block_allocator_unit_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// grouped_free_block_allocator_unit_tb
// Self-checking bench for the grouped free block allocator. A shadow free
// list tracks the stack, the refill counter and the modified flag. From these
// it predicts every response transaction. Directed sequences come first.
// They are followed by random fill, drain, spill and refill traffic with
// random gaps on both channels, and then by a long response stall.
// ============================================================================
module grouped_free_block_allocator_unit_tb;

   localparam int GSZ          = gfba_pkg::GROUP_SIZE_DEF;
   localparam int DRAIN_CYCLES = 10;

   typedef logic [gfba_pkg::WORD_W-1:0]   word_type;
   typedef logic [gfba_pkg::OP_W-1:0]     op_type;
   typedef logic [gfba_pkg::STATUS_W-1:0] status_type;

   typedef struct {
      status_type status;
      word_type   blk;
      word_type   word;
      logic       last;
      logic       modified;
   } alloc_rsp_type;

   logic clock;
   logic reset;

   gfba_req_if req_chan ();
   gfba_rsp_if rsp_chan ();

   grouped_free_block_allocator_unit #(
      .GROUP_SIZE (GSZ)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow copy of the free list.
   word_type fl_stack [GSZ];
   int       fl_count       = 0;
   int       fl_refill_left = 0;
   logic     fl_dirty       = 1'b0;
   int       spills_seen    = 0;

   // Responses still owed by the block, oldest first.
   alloc_rsp_type awaited_rsps [$];
   int            rsp_errors = 0;

   // Traffic shaping shared by the stimulus and the response side.
   bit tx_idle        = 1'b1;
   bit rx_idle        = 1'b1;
   int rx_hold_cycles = 0;
   bit fill_mode      = 1'b1;
   int spill_mark     = 0;

   // 10 ns clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Count a mismatch and print one line for it.
   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      rsp_errors++;
      $display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h",
               $time, what, want, got);
   endtask

   // Append one predicted response carrying the current modified flag.
   task automatic queue_rsp(input status_type status, input word_type blk,
                            input word_type word, input logic last);
      alloc_rsp_type r;
      r.status   = status;
      r.blk      = blk;
      r.word     = word;
      r.last     = last;
      r.modified = fl_dirty;
      awaited_rsps.push_back(r);
   endtask

   // Apply one accepted request to the shadow free list and queue its responses.
   task automatic free_list_step(input op_type op, input word_type blk,
                                 input word_type word);
      word_type popped;
      case (op)
         gfba_pkg::OP_SYNC: begin
            fl_dirty = 1'b0;
            queue_rsp(gfba_pkg::ST_OK, '0, '0, 1'b1);
         end
         gfba_pkg::OP_REFILL: begin
            if (fl_refill_left == 0) begin
               queue_rsp(gfba_pkg::ST_SEQERR, '0, '0, 1'b1);
            end else begin
               // The first word is the count; the rest fill the entries from the bottom.
               if (fl_refill_left == GSZ + 1) begin
                  fl_count = (word > GSZ) ? GSZ : int'(word);
               end else begin
                  fl_stack[GSZ - fl_refill_left] = word;
               end
               fl_refill_left--;
               queue_rsp(gfba_pkg::ST_OK, '0, '0, 1'b1);
            end
         end
         default: begin
            if (fl_refill_left != 0) begin
               queue_rsp(gfba_pkg::ST_SEQERR, '0, '0, 1'b1);
            end else if (op == gfba_pkg::OP_ALLOC) begin
               if (fl_count == 0) begin
                  queue_rsp(gfba_pkg::ST_NOSPACE, '0, '0, 1'b1);
               end else begin
                  fl_count--;
                  popped = fl_stack[fl_count];
                  if (popped == '0) begin
                     // The end marker empties the list without touching the flag.
                     fl_count = 0;
                     queue_rsp(gfba_pkg::ST_NOSPACE, '0, '0, 1'b1);
                  end else begin
                     fl_dirty = 1'b1;
                     if (fl_count == 0) begin
                        fl_refill_left = GSZ + 1;
                        queue_rsp(gfba_pkg::ST_REFILL, popped, '0, 1'b1);
                     end else begin
                        queue_rsp(gfba_pkg::ST_OK, popped, '0, 1'b1);
                     end
                  end
               end
            end else begin
               fl_dirty = 1'b1;
               if (fl_count == 0) begin
                  fl_stack[0] = '0;
                  fl_count    = 1;
               end
               if (fl_count >= GSZ) begin
                  // A full group is written out into the freed block first.
                  queue_rsp(gfba_pkg::ST_SPILL, blk, word_type'(fl_count), 1'b0);
                  for (int i = 0; i < GSZ; i++) begin
                     queue_rsp(gfba_pkg::ST_SPILL, blk, fl_stack[i], i == GSZ - 1);
                  end
                  fl_stack[0] = blk;
                  fl_count    = 1;
                  spills_seen++;
               end else begin
                  fl_stack[fl_count] = blk;
                  fl_count++;
                  queue_rsp(gfba_pkg::ST_OK, '0, '0, 1'b1);
               end
            end
         end
      endcase
   endtask

   // Offer one request after a random gap and hold it until it is accepted.
   task automatic send_request(input op_type op, input word_type blk,
                               input word_type word);
      int gap;
      gap = tx_idle ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.operation    <= op;
      req_chan.block_number <= blk;
      req_chan.fill_word    <= word;
      do @(posedge clock); while (!req_chan.ready);
      free_list_step(op, blk, word);
   endtask

   // Drop valid and wait until every predicted response has arrived.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (awaited_rsps.size() != 0);
   endtask

   // Pick a request that mostly follows a sensible fill, drain or refill flow.
   task automatic random_request();
      int       r;
      word_type w;
      r = $urandom_range(0, 99);
      if (fl_refill_left != 0 && r < 90) begin
         if (fl_refill_left == GSZ + 1) begin
            case ($urandom_range(0, 3))
               0:       w = word_type'($urandom_range(0, 3));
               1:       w = word_type'(GSZ);
               2:       w = word_type'($urandom_range(0, GSZ));
               default: w = word_type'($urandom);
            endcase
         end else begin
            w = ($urandom_range(0, 11) == 0) ? '0 : word_type'($urandom);
         end
         send_request(gfba_pkg::OP_REFILL, word_type'($urandom), w);
      end else if (r < 5) begin
         send_request(op_type'($urandom_range(0, 3)), word_type'($urandom),
                      word_type'($urandom));
      end else if (r < (fill_mode ? 85 : 15)) begin
         w = ($urandom_range(0, 19) == 0) ? '0 : word_type'($urandom);
         send_request(gfba_pkg::OP_FREE, w, word_type'($urandom));
      end else if (r < 94) begin
         send_request(gfba_pkg::OP_ALLOC, word_type'($urandom), word_type'($urandom));
      end else begin
         send_request(gfba_pkg::OP_SYNC, word_type'($urandom), word_type'($urandom));
      end

      // Drain after a spill, and fill again once the list is empty.
      if (fill_mode && (spills_seen != spill_mark || $urandom_range(0, 99) == 0)) begin
         fill_mode = 1'b0;
      end else if (!fill_mode && fl_refill_left == 0 &&
                   (fl_count == 0 || $urandom_range(0, 99) == 0)) begin
         fill_mode  = 1'b1;
         spill_mark = spills_seen;
      end
   endtask

   // Empty list: allocate, a stray refill word and sync, with extreme fields.
   task automatic test_empty_stack();
      send_request(gfba_pkg::OP_ALLOC, '1, '1);
      send_request(gfba_pkg::OP_REFILL, '0, '1);
      send_request(gfba_pkg::OP_SYNC, '1, '1);
      send_request(gfba_pkg::OP_SYNC, '0, '0);
      wait_drained();
   endtask

   // Pushes and pops around the end marker, including freeing block zero.
   task automatic test_push_pop();
      send_request(gfba_pkg::OP_FREE, '1, '0);
      send_request(gfba_pkg::OP_FREE, '0, '1);
      send_request(gfba_pkg::OP_FREE, 24'h000001, '0);
      send_request(gfba_pkg::OP_ALLOC, '0, '0);
      send_request(gfba_pkg::OP_ALLOC, '0, '0);
      send_request(gfba_pkg::OP_ALLOC, '1, '1);
      send_request(gfba_pkg::OP_SYNC, '0, '0);
      send_request(gfba_pkg::OP_FREE, 24'h800000, 24'h555555);
      send_request(gfba_pkg::OP_FREE, 24'h555555, 24'hAAAAAA);
      send_request(gfba_pkg::OP_REFILL, 24'hAAAAAA, 24'h555555);
      send_request(gfba_pkg::OP_ALLOC, '0, '0);
      send_request(gfba_pkg::OP_ALLOC, '0, '0);
      send_request(gfba_pkg::OP_ALLOC, '0, '0);
      send_request(gfba_pkg::OP_ALLOC, '0, '0);
      wait_drained();
   endtask

   // Random traffic in segments with different idling, and sometimes a pause between them.
   task automatic test_random_traffic(input int n_items);
      int seg;
      for (int k = 0; k < n_items; k++) begin
         if (k % 50 == 0) begin
            seg     = k / 50;
            tx_idle = (seg != 2);
            rx_idle = (seg != 2) && (seg != 4);
         end
         random_request();
         if (k % 50 == 49 && $urandom_range(0, 1) == 0) begin
            wait_drained();
         end
      end
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      wait_drained();
   endtask

   // Hold the response side off for a long time while requests keep coming.
   task automatic test_output_stall();
      tx_idle        = 1'b0;
      rx_hold_cycles = 150;
      repeat (30) random_request();
      tx_idle = 1'b1;
      wait_drained();
   endtask

   // Response side: random ready gaps, and a long hold when requested.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rx_hold_cycles > 0) begin
            rx_hold_cycles--;
            rsp_chan.ready <= 1'b0;
         end else if (rsp_chan.ready && rsp_chan.valid) begin
            stall_left = rx_idle ? $urandom_range(0, 5) : 0;
            rsp_chan.ready <= (stall_left == 0);
         end else if (!rsp_chan.ready) begin
            if (stall_left > 0) begin
               stall_left--;
            end
            rsp_chan.ready <= (stall_left == 0);
         end
      end
   end

   // Compare each response transaction with the oldest prediction.
   always @(posedge clock) begin : rsp_check
      alloc_rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (awaited_rsps.size() == 0) begin
            report_mismatch("response with none awaited, status", '0,
                            32'(rsp_chan.status));
         end else begin
            want = awaited_rsps.pop_front();
            if (rsp_chan.status !== want.status) begin
               report_mismatch("status", 32'(want.status), 32'(rsp_chan.status));
            end
            if (rsp_chan.block_number_out !== want.blk) begin
               report_mismatch("block_number_out", 32'(want.blk),
                               32'(rsp_chan.block_number_out));
            end
            if (rsp_chan.spill_word !== want.word) begin
               report_mismatch("spill_word", 32'(want.word), 32'(rsp_chan.spill_word));
            end
            if (rsp_chan.last !== want.last) begin
               report_mismatch("last", 32'(want.last), 32'(rsp_chan.last));
            end
            if (rsp_chan.modified !== want.modified) begin
               report_mismatch("modified", 32'(want.modified), 32'(rsp_chan.modified));
            end
         end
      end
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #20_000_000;
      $display("grouped_free_block_allocator_unit_tb: done, errors");
      $finish;
   end

   // Test sequence.
   initial begin
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.operation    <= gfba_pkg::OP_SYNC;
      req_chan.block_number <= '0;
      req_chan.fill_word    <= '0;
      for (int i = 0; i < GSZ; i++) begin
         fl_stack[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_empty_stack();
      test_push_pop();
      test_random_traffic(300);
      test_output_stall();

      // Leftover predictions are errors as well.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (awaited_rsps.size() != 0) begin
         report_mismatch("responses still awaited", '0, 32'(awaited_rsps.size()));
      end
      if (rsp_errors == 0) begin
         $display("grouped_free_block_allocator_unit_tb: done, clean");
      end else begin
         $display("grouped_free_block_allocator_unit_tb: done, errors");
      end
      $finish;
   end

endmodule
